// File: rtl/bffa_pkg.sv
package bffa_pkg;

  localparam int unsigned HeapBytes = 4096;
  localparam int unsigned WordBits  = 16;
  localparam int unsigned Words     = HeapBytes / WordBits;
  localparam int unsigned IdxW      = $clog2(HeapBytes);
  localparam int unsigned BitW      = $clog2(WordBits);
  localparam int unsigned PtrW      = IdxW - BitW;
  localparam int unsigned RunW      = IdxW + 1;
  localparam int unsigned StackW    = 16;
  localparam int unsigned AddrW     = 17;
  localparam int unsigned SizeW     = 13;
  localparam int unsigned StatW     = 3;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [StatW-1:0] {
    ST_OK          = 3'd0,
    ST_OVERFLOW    = 3'd1,
    ST_FRAGMENTED  = 3'd2,
    ST_ACCESS      = 3'd3,
    ST_DOUBLE_FREE = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    RD_NEXT,
    RD_ZERO,
    RD_RANGE
  } rd_sel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SRCH_PRIME,
    S_SEARCH,
    S_MARK_INIT,
    S_MARK_PRIME,
    S_MARK,
    S_CLR_PRIME,
    S_CLEAR,
    S_DONE
  } state_e;

  typedef struct packed {
    logic    load_item;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    run_clr;
    logic    srch_step;
    logic    set_rng_alloc;
    logic    set_rng_free;
    logic    wr_mark;
    logic    wr_clear;
    logic    set_stat;
    status_e stat;
    logic    stat_addr;
    logic    load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic is_free;
    logic size_zero;
    logic range_err;
    logic hit;
    logic srch_last;
    logic run_last;
    logic dbl;
  } dp_stat_t;

endpackage

// File: rtl/bffa_if.sv
interface bffa_req_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [bffa_pkg::AddrW-1:0]  address;
  logic [bffa_pkg::SizeW-1:0]  size;
  modport source (output valid, output cmd, output address, output size, input ready);
  modport sink (input valid, input cmd, input address, input size, output ready);
endinterface

interface bffa_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [bffa_pkg::StatW-1:0]  status;
  logic [bffa_pkg::AddrW-1:0]  alloc_address;
  modport source (output valid, output status, output alloc_address, input ready);
  modport sink (input valid, input status, input alloc_address, output ready);
endinterface

interface bffa_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [bffa_pkg::StackW-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/bffa_ctrl.sv
module bffa_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  output logic               rsp_valid_o,
  input  logic               rsp_ready_i,
  input  bffa_pkg::dp_stat_t stat_i,
  output bffa_pkg::dp_cmd_t  cmd_o
);

  bffa_pkg::state_e state_q, state_d;
  logic             out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bffa_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      bffa_pkg::S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = bffa_pkg::S_CHECK;
        end
      end
      bffa_pkg::S_CHECK: begin
        if (!stat_i.is_free) begin
          if (stat_i.size_zero) begin
            cmd_o.set_stat = 1'b1;
            cmd_o.stat     = bffa_pkg::ST_FRAGMENTED;
            state_d        = bffa_pkg::S_DONE;
          end else begin
            cmd_o.run_clr = 1'b1;
            state_d       = bffa_pkg::S_SRCH_PRIME;
          end
        end else if (stat_i.range_err) begin
          cmd_o.set_stat = 1'b1;
          cmd_o.stat     = bffa_pkg::ST_ACCESS;
          state_d        = bffa_pkg::S_DONE;
        end else if (stat_i.size_zero) begin
          cmd_o.set_stat = 1'b1;
          cmd_o.stat     = bffa_pkg::ST_OK;
          state_d        = bffa_pkg::S_DONE;
        end else begin
          cmd_o.set_rng_free = 1'b1;
          state_d            = bffa_pkg::S_CLR_PRIME;
        end
      end
      bffa_pkg::S_SRCH_PRIME: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = bffa_pkg::RD_ZERO;
        state_d      = bffa_pkg::S_SEARCH;
      end
      bffa_pkg::S_SEARCH: begin
        cmd_o.rd_en     = 1'b1;
        cmd_o.rd_sel    = bffa_pkg::RD_NEXT;
        cmd_o.srch_step = 1'b1;
        if (stat_i.hit) begin
          state_d = bffa_pkg::S_MARK_INIT;
        end else if (stat_i.srch_last) begin
          cmd_o.set_stat = 1'b1;
          cmd_o.stat     = bffa_pkg::ST_OVERFLOW;
          state_d        = bffa_pkg::S_DONE;
        end
      end
      bffa_pkg::S_MARK_INIT: begin
        cmd_o.set_rng_alloc = 1'b1;
        state_d             = bffa_pkg::S_MARK_PRIME;
      end
      bffa_pkg::S_MARK_PRIME: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = bffa_pkg::RD_RANGE;
        state_d      = bffa_pkg::S_MARK;
      end
      bffa_pkg::S_MARK: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_sel  = bffa_pkg::RD_NEXT;
        cmd_o.wr_mark = 1'b1;
        if (stat_i.run_last) begin
          cmd_o.set_stat  = 1'b1;
          cmd_o.stat      = bffa_pkg::ST_OK;
          cmd_o.stat_addr = 1'b1;
          state_d         = bffa_pkg::S_DONE;
        end
      end
      bffa_pkg::S_CLR_PRIME: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = bffa_pkg::RD_RANGE;
        state_d      = bffa_pkg::S_CLEAR;
      end
      bffa_pkg::S_CLEAR: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_sel   = bffa_pkg::RD_NEXT;
        cmd_o.wr_clear = 1'b1;
        if (stat_i.dbl) begin
          cmd_o.set_stat = 1'b1;
          cmd_o.stat     = bffa_pkg::ST_DOUBLE_FREE;
          state_d        = bffa_pkg::S_DONE;
        end else if (stat_i.run_last) begin
          cmd_o.set_stat = 1'b1;
          cmd_o.stat     = bffa_pkg::ST_OK;
          state_d        = bffa_pkg::S_DONE;
        end
      end
      bffa_pkg::S_DONE: begin
        if (!out_valid_q || rsp_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = bffa_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bffa_pkg::S_IDLE;
      end
    endcase
  end

  assign req_ready_o = (state_q == bffa_pkg::S_IDLE);
  assign rsp_valid_o = out_valid_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || rsp_ready_i))
    else $error("Result register overwritten while a transaction was pending.");

  a_accept_to_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_o) |=> (state_q == bffa_pkg::S_CHECK))
    else $error("Accepted transaction was not checked in the next cycle.");

  a_one_write_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.wr_mark && cmd_o.wr_clear))
    else $error("Mark and clear requested in the same cycle.");

endmodule

// File: rtl/bffa_dp.sv
module bffa_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bffa_pkg::dp_cmd_t           cmd_i,
  output bffa_pkg::dp_stat_t          stat_o,
  input  logic                        req_cmd_i,
  input  logic [bffa_pkg::AddrW-1:0]  req_address_i,
  input  logic [bffa_pkg::SizeW-1:0]  req_size_i,
  input  logic                        cfg_valid_i,
  input  logic [bffa_pkg::StackW-1:0] cfg_data_i,
  output logic [bffa_pkg::StatW-1:0]  rsp_status_o,
  output logic [bffa_pkg::AddrW-1:0]  rsp_address_o
);

  localparam int unsigned WB = bffa_pkg::WordBits;

  logic [WB-1:0]                 mem [bffa_pkg::Words];
  logic [bffa_pkg::Words-1:0]    row_vld_q;
  logic [WB-1:0]                 rdata_q;
  logic                          rvld_q;
  logic [WB-1:0]                 word;

  bffa_pkg::op_e                 op_q;
  logic [bffa_pkg::AddrW-1:0]    addr_q;
  logic [bffa_pkg::SizeW-1:0]    size_q;
  logic [bffa_pkg::StackW-1:0]   stack_q;

  logic [bffa_pkg::PtrW-1:0]     rd_ptr_q, cur_q, rd_addr;
  logic [bffa_pkg::RunW-1:0]     run_q, run_d;
  logic [bffa_pkg::IdxW-1:0]     end_q, end_idx;
  logic [bffa_pkg::IdxW-1:0]     rng_lo_q, rng_hi_q;
  bffa_pkg::status_e             stat_q, out_status_q;
  logic [bffa_pkg::AddrW-1:0]    res_addr_q, out_addr_q;

  logic [bffa_pkg::AddrW-1:0]    total, base;
  logic [bffa_pkg::AddrW:0]      addr_end;
  logic                          range_err;
  logic [bffa_pkg::IdxW-1:0]     free_hi, alloc_lo;

  logic [WB-1:0]                 any_used;
  logic [bffa_pkg::BitW-1:0]     last_used [WB];
  logic [bffa_pkg::RunW:0]       run_k [WB];
  logic [WB-1:0]                 hit_vec;
  logic [bffa_pkg::BitW-1:0]     hit_pos;

  logic [bffa_pkg::BitW-1:0]     lo_b, hi_b;
  logic [WB-1:0]                 mask, clr, first, keep;
  logic                          dbl;
  logic                          wr_en;
  logic [WB-1:0]                 wdata;

  assign word = rvld_q ? rdata_q : '0;

  // Range checks for a free transaction.
  assign total     = bffa_pkg::AddrW'(stack_q) + bffa_pkg::AddrW'(bffa_pkg::HeapBytes);
  assign addr_end  = (bffa_pkg::AddrW+1)'(addr_q) + (bffa_pkg::AddrW+1)'(size_q);
  assign range_err = (addr_q >= total) || (addr_end > (bffa_pkg::AddrW+1)'(total)) ||
                     (addr_q < bffa_pkg::AddrW'(stack_q));
  assign base      = addr_q - bffa_pkg::AddrW'(stack_q);
  assign free_hi   = base[bffa_pkg::IdxW-1:0] + size_q[bffa_pkg::IdxW-1:0] -
                     bffa_pkg::IdxW'(1);
  assign alloc_lo  = bffa_pkg::IdxW'(bffa_pkg::RunW'(end_q) + bffa_pkg::RunW'(1) -
                     bffa_pkg::RunW'(size_q));

  // First-fit search over one word: length of the free run ending at each bit.
  always_comb begin
    for (int k = 0; k < WB; k++) begin
      any_used[k]  = 1'b0;
      last_used[k] = '0;
      for (int i = 0; i <= k; i++) begin
        if (word[i]) begin
          any_used[k]  = 1'b1;
          last_used[k] = bffa_pkg::BitW'(i);
        end
      end
      run_k[k] = any_used[k] ?
                 (bffa_pkg::RunW+1)'(k) - (bffa_pkg::RunW+1)'(last_used[k]) :
                 (bffa_pkg::RunW+1)'(run_q) + (bffa_pkg::RunW+1)'(k + 1);
      hit_vec[k] = !word[k] && (run_k[k] >= (bffa_pkg::RunW+1)'(size_q));
    end
    hit_pos = '0;
    for (int k = WB - 1; k >= 0; k--) begin
      if (hit_vec[k]) begin
        hit_pos = bffa_pkg::BitW'(k);
      end
    end
  end

  assign run_d   = any_used[WB-1] ?
                   bffa_pkg::RunW'(WB - 1) - bffa_pkg::RunW'(last_used[WB-1]) :
                   run_q + bffa_pkg::RunW'(WB);
  assign end_idx = {cur_q, hit_pos};

  // Bit mask of the current word inside the marked or freed range.
  assign lo_b = (cur_q == rng_lo_q[bffa_pkg::IdxW-1:bffa_pkg::BitW]) ?
                rng_lo_q[bffa_pkg::BitW-1:0] : '0;
  assign hi_b = (cur_q == rng_hi_q[bffa_pkg::IdxW-1:bffa_pkg::BitW]) ?
                rng_hi_q[bffa_pkg::BitW-1:0] : '1;

  always_comb begin
    for (int k = 0; k < WB; k++) begin
      mask[k] = (bffa_pkg::BitW'(k) >= lo_b) && (bffa_pkg::BitW'(k) <= hi_b);
    end
  end

  // A free stops at the lowest bit in range that is already clear.
  assign clr   = mask & ~word;
  assign dbl   = |clr;
  assign first = clr & (~clr + WB'(1));
  assign keep  = dbl ? (mask & (first - WB'(1))) : mask;
  assign wdata = cmd_i.wr_mark ? (word | mask) : (word & ~keep);
  assign wr_en = cmd_i.wr_mark || cmd_i.wr_clear;

  always_comb begin
    case (cmd_i.rd_sel)
      bffa_pkg::RD_ZERO:  rd_addr = '0;
      bffa_pkg::RD_RANGE: rd_addr = rng_lo_q[bffa_pkg::IdxW-1:bffa_pkg::BitW];
      default:            rd_addr = rd_ptr_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[cur_q] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rvld_q    <= 1'b0;
      rd_ptr_q  <= '0;
      cur_q     <= '0;
      stack_q   <= '0;
      run_q     <= '0;
    end else begin
      if (wr_en) begin
        row_vld_q[cur_q] <= 1'b1;
      end
      if (cmd_i.rd_en) begin
        rvld_q   <= row_vld_q[rd_addr];
        rd_ptr_q <= rd_addr + bffa_pkg::PtrW'(1);
        cur_q    <= rd_addr;
      end
      if (cfg_valid_i) begin
        stack_q <= cfg_data_i;
      end
      if (cmd_i.run_clr) begin
        run_q <= '0;
      end else if (cmd_i.srch_step) begin
        run_q <= run_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q   <= bffa_pkg::op_e'(req_cmd_i);
      addr_q <= req_address_i;
      size_q <= req_size_i;
    end
    if (cmd_i.srch_step && (|hit_vec)) begin
      end_q <= end_idx;
    end
    if (cmd_i.set_rng_free) begin
      rng_lo_q <= base[bffa_pkg::IdxW-1:0];
      rng_hi_q <= free_hi;
    end else if (cmd_i.set_rng_alloc) begin
      rng_lo_q <= alloc_lo;
      rng_hi_q <= end_q;
    end
    if (cmd_i.set_stat) begin
      stat_q     <= cmd_i.stat;
      res_addr_q <= cmd_i.stat_addr ?
                    bffa_pkg::AddrW'(stack_q) + bffa_pkg::AddrW'(rng_lo_q) : '0;
    end
    if (cmd_i.load_out) begin
      out_status_q <= stat_q;
      out_addr_q   <= res_addr_q;
    end
  end

  assign stat_o.is_free   = (op_q == bffa_pkg::OP_FREE);
  assign stat_o.size_zero = (size_q == '0);
  assign stat_o.range_err = range_err;
  assign stat_o.hit       = |hit_vec;
  assign stat_o.srch_last = (cur_q == bffa_pkg::PtrW'(bffa_pkg::Words - 1));
  assign stat_o.run_last  = (cur_q == rng_hi_q[bffa_pkg::IdxW-1:bffa_pkg::BitW]);
  assign stat_o.dbl       = dbl;

  assign rsp_status_o  = out_status_q;
  assign rsp_address_o = out_addr_q;

  a_mark_on_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_mark |-> ((word & mask) == '0))
    else $error("Allocation marks a byte that is already in use.");

  a_clear_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_clear |-> ((wdata & ~word) == '0))
    else $error("Free sets a bit in the occupancy map.");

  a_start_in_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.srch_step && (|hit_vec)) |->
    ((bffa_pkg::RunW'(end_idx) + bffa_pkg::RunW'(1)) >= bffa_pkg::RunW'(size_q)))
    else $error("Found run starts below the heap.");

endmodule

// File: rtl/bitmap_first_fit_allocator_top.sv
// Channel  Modport  Payload                        Transaction
// req_i    sink     cmd, address, size             valid && ready at clk_i rise
// rsp_o    source   status, alloc_address          valid && ready at clk_i rise
// cfg_i    sink     data (stack_size)              valid && ready, ready always high
//
// The occupancy map is kept as 256 words of 16 bits in a one-read, one-write memory.
// An allocate scans words until the run is found (up to 256 words scanned), then marks the
// words the run spans (up to 256); if no fit is found it ends with an overflow status.
// A free clears the words it touches; zero size or a bad range is settled in the check state.
// Reset clears per-word valid bits at once, so the map reads as free with no sweep.
// A new transaction is accepted while the previous result waits on rsp_o.
module bitmap_first_fit_allocator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  bffa_req_if.sink    req_i,
  bffa_rsp_if.source  rsp_o,
  bffa_cfg_if.sink    cfg_i
);

  bffa_pkg::dp_cmd_t  dp_cmd;
  bffa_pkg::dp_stat_t dp_stat;

  assign cfg_i.ready = 1'b1;

  bffa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd)
  );

  bffa_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (dp_cmd),
    .stat_o        (dp_stat),
    .req_cmd_i     (req_i.cmd),
    .req_address_i (req_i.address),
    .req_size_i    (req_i.size),
    .cfg_valid_i   (cfg_i.valid),
    .cfg_data_i    (cfg_i.data),
    .rsp_status_o  (rsp_o.status),
    .rsp_address_o (rsp_o.alloc_address)
  );

endmodule
